FILE: hdl/psmw_pkg.sv
package psmw_pkg;

    localparam int TIME_W     = 31;
    localparam int DUR_W      = 31;
    localparam int SEN_W      = 20;
    localparam int NOW_W      = 40;
    localparam int WAIT_W     = 32;
    localparam int ENTRY_W    = TIME_W + DUR_W + SEN_W;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    localparam logic [WAIT_W-1:0] NO_WAIT  = '1;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 32'h7FFF_FFFF;
    localparam logic [NOW_W-1:0]  NOW_MAX  = '1;

    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;

    typedef struct packed {
        logic [SEN_W-1:0]  sen;
        logic [DUR_W-1:0]  dur;
        logic [TIME_W-1:0] arrive;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic calc_gap;
        logic complete_arr;
        logic complete_flush;
        logic advance;
        logic cnt_clear;
        logic scan_step;
        logic pick;
        logic free_step;
        logic start_direct;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic busy;
        logic complete;
        logic scan_done;
        logic free_done;
    } status_t;

endpackage

FILE: hdl/psmw_ram.sv
module psmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/psmw_ctrl.sv
module psmw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  psmw_pkg::status_t  status,
    output psmw_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GAP   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_START = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                cmd.calc_gap = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.kind == psmw_pkg::KIND_FLUSH)
                begin
                    if (status.busy)
                    begin
                        cmd.complete_flush = 1'b1;
                        cmd.cnt_clear      = 1'b1;
                        state_next         = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (status.complete)
                begin
                    cmd.complete_arr = 1'b1;
                    cmd.cnt_clear    = 1'b1;
                    state_next       = S_SCAN;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    if (status.busy)
                    begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = S_FREE;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_CHECK;
            end
            S_FREE:
            begin
                cmd.free_step = 1'b1;
                if (status.free_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_START:
            begin
                cmd.start_direct = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

FILE: hdl/psmw_datapath.sv
module psmw_datapath #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  psmw_pkg::cmd_t                       cmd,
    output psmw_pkg::status_t                    status,
    input  logic [psmw_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tuser,
    output logic [psmw_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int TW     = psmw_pkg::TIME_W;
    localparam int DW     = psmw_pkg::DUR_W;
    localparam int SW     = psmw_pkg::SEN_W;
    localparam int NW     = psmw_pkg::NOW_W;
    localparam int WW     = psmw_pkg::WAIT_W;
    localparam int OUT_PAD = psmw_pkg::OUT_DATA_W - WW - 2;
    localparam logic [CW-1:0] CNT_END = CW'(QUEUE_DEPTH);

    logic                   kind_reg;
    logic [TW-1:0]          t_reg;
    logic [DW-1:0]          dur_reg;
    logic [SW-1:0]          sen_reg;
    logic [NW-1:0]          now_reg,  now_next;
    logic [DW-1:0]          left_reg, left_next;
    logic                   busy_reg, busy_next;
    logic [WW-1:0]          worst_reg, worst_next;
    logic [TW-1:0]          gap_reg,  gap_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]          cnt_reg,  cnt_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          pend_idx_reg;
    logic                   found_reg, found_next;
    logic [AW-1:0]          best_idx_reg, best_idx_next;
    logic [SW-1:0]          best_sen_reg, best_sen_next;
    logic [TW-1:0]          best_arr_reg, best_arr_next;
    logic [DW-1:0]          best_dur_reg, best_dur_next;
    logic                   drop_reg, drop_next;
    logic [psmw_pkg::OUT_DATA_W-1:0] out_data_reg;

    psmw_pkg::entry_t       wr_entry;
    psmw_pkg::entry_t       rd_entry;
    logic [psmw_pkg::ENTRY_W-1:0] rd_bits;

    logic                   scan_issue;
    logic                   free_at_end;
    logic                   free_hit;
    logic                   better;
    logic [NW-1:0]          t_ext;
    logic [NW-1:0]          arr_ext;
    logic [NW-1:0]          diff;
    logic [WW-1:0]          wait_val;
    logic [WW-1:0]          worst_upd;
    logic [NW:0]            flush_sum;
    logic [NW:0]            adv_sum;

    assign wr_entry.arrive = t_reg;
    assign wr_entry.dur    = dur_reg;
    assign wr_entry.sen    = sen_reg;
    assign rd_entry        = psmw_pkg::entry_t'(rd_bits);

    assign scan_issue  = cmd.scan_step && (cnt_reg != CNT_END);
    assign free_at_end = (cnt_reg == CNT_END);
    assign free_hit    = !free_at_end && !valid_reg[cnt_reg[AW-1:0]];

    psmw_ram #(
        .WIDTH (psmw_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.free_step && free_hit),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (wr_entry),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_bits)
    );

    assign status.kind      = kind_reg;
    assign status.busy      = busy_reg;
    assign status.complete  = busy_reg && (left_reg < gap_reg);
    assign status.scan_done = (cnt_reg == CNT_END) && !pend_reg;
    assign status.free_done = free_at_end || free_hit;

    assign m_tdata = out_data_reg;

    assign t_ext   = {{(NW-TW){1'b0}}, t_reg};
    assign arr_ext = {{(NW-TW){1'b0}}, (cmd.pick ? best_arr_reg : t_reg)};
    assign diff    = (now_reg > arr_ext) ? (now_reg - arr_ext) : '0;
    assign wait_val = (diff > {{(NW-WW){1'b0}}, psmw_pkg::WAIT_MAX}) ? psmw_pkg::WAIT_MAX
                                                                      : diff[WW-1:0];
    assign worst_upd = ((worst_reg == psmw_pkg::NO_WAIT) || (wait_val > worst_reg))
                       ? wait_val : worst_reg;

    assign flush_sum = {1'b0, now_reg} + {{(NW+1-DW){1'b0}}, left_reg};
    assign adv_sum   = {1'b0, now_reg} + {{(NW+1-TW){1'b0}}, gap_reg};

    assign better = pend_reg && valid_reg[pend_idx_reg]
                    && (!found_reg || (rd_entry.sen < best_sen_reg));

    always_comb
    begin
        now_next      = now_reg;
        left_next     = left_reg;
        busy_next     = busy_reg;
        worst_next    = worst_reg;
        gap_next      = gap_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        pend_next     = scan_issue;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_sen_next = best_sen_reg;
        best_arr_next = best_arr_reg;
        best_dur_next = best_dur_reg;
        drop_next     = drop_reg;

        if (cmd.latch)
        begin
            drop_next = 1'b0;
        end
        if (cmd.calc_gap)
        begin
            gap_next = (t_ext > now_reg) ? TW'(t_ext - now_reg) : '0;
        end
        if (cmd.complete_arr)
        begin
            now_next = now_reg + {{(NW-DW){1'b0}}, left_reg};
            gap_next = gap_reg - left_reg;
        end
        if (cmd.complete_flush)
        begin
            now_next  = flush_sum[NW] ? psmw_pkg::NOW_MAX : flush_sum[NW-1:0];
            left_next = '0;
        end
        if (cmd.advance)
        begin
            if (busy_reg)
            begin
                left_next = left_reg - gap_reg;
            end
            now_next = adv_sum[NW] ? psmw_pkg::NOW_MAX : adv_sum[NW-1:0];
        end
        if (cmd.cnt_clear)
        begin
            cnt_next   = '0;
            found_next = 1'b0;
        end
        if (scan_issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (better)
        begin
            found_next    = 1'b1;
            best_idx_next = pend_idx_reg;
            best_sen_next = rd_entry.sen;
            best_arr_next = rd_entry.arrive;
            best_dur_next = rd_entry.dur;
        end
        if (cmd.pick)
        begin
            if (found_reg)
            begin
                left_next                = best_dur_reg;
                busy_next                = 1'b1;
                valid_next[best_idx_reg] = 1'b0;
                worst_next               = worst_upd;
            end
            else
            begin
                left_next = '0;
                busy_next = 1'b0;
            end
        end
        if (cmd.free_step)
        begin
            if (free_at_end)
            begin
                drop_next = 1'b1;
            end
            else if (free_hit)
            begin
                valid_next[cnt_reg[AW-1:0]] = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (cmd.start_direct)
        begin
            left_next  = dur_reg;
            busy_next  = 1'b1;
            worst_next = worst_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg   <= '0;
            left_reg  <= '0;
            busy_reg  <= 1'b0;
            worst_reg <= psmw_pkg::NO_WAIT;
            valid_reg <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            now_reg   <= now_next;
            left_reg  <= left_next;
            busy_reg  <= busy_next;
            worst_reg <= worst_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= s_tuser;
            t_reg    <= s_tdata[TW-1:0];
            dur_reg  <= s_tdata[TW+DW-1:TW];
            sen_reg  <= s_tdata[TW+DW+SW-1:TW+DW];
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{OUT_PAD{1'b0}},
                             (kind_reg == psmw_pkg::KIND_FLUSH), drop_reg, worst_reg};
        end
        gap_reg      <= gap_next;
        pend_idx_reg <= cnt_reg[AW-1:0];
        best_idx_reg <= best_idx_next;
        best_sen_reg <= best_sen_next;
        best_arr_reg <= best_arr_next;
        best_dur_reg <= best_dur_next;
    end

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (valid_reg == '0))
        else $error("idle server with waiting requests");

    a_worst_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (worst_reg != psmw_pkg::NO_WAIT) |=>
        ((worst_reg != psmw_pkg::NO_WAIT) && (worst_reg >= $past(worst_reg))))
        else $error("worst wait decreased");

    a_clock_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (now_reg >= $past(now_reg)))
        else $error("simulated clock moved back");

    a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick && found_reg) |=> busy_reg)
        else $error("request picked but server not busy");

endmodule

FILE: hdl/priority_server_max_wait_top.sv
// Channel  Dir  Handshake           Payload
// s        in   s_tvalid/s_tready   s_tdata, s_tuser (kind)
// m        out  m_tvalid/m_tready   m_tdata
//
// An arrival with no completion passes through the gap and check states on an idle
// server and then starts service directly; while busy it instead searches the valid
// bits for a free slot. Each completion runs one scan of the store RAM, one read a
// cycle, for the lowest seniority. A flush finishes the request in service and then
// runs that scan for each one still queued.
// Reset clears all valid bits at once; no clearing pass is needed.
// A result waiting on m_tready does not block acceptance of the next transaction.
module priority_server_max_wait_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // arrive_time[30:0], duration[61:31], seniority[81:62], zero [87:82]
    input  logic [psmw_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // max_wait[31:0], dropped[32], drained[33], zero [39:34]
    output logic [psmw_pkg::OUT_DATA_W-1:0]     m_tdata
);

    psmw_pkg::cmd_t    cmd;
    psmw_pkg::status_t status;

    psmw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psmw_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule
